// ===== src/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg: shared constants and types of the bit stream concatenator
// Word and counter widths, and the result word record used by the queue.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int WordWidth  = 64;
  localparam int TotalWidth = 40;
  // Bit count of one word, 0..WordWidth inclusive.
  localparam int CountWidth = $clog2(WordWidth + 1);
  // Residual bit count, always below WordWidth.
  localparam int ResWidth   = $clog2(WordWidth);
  // Result queue: one item may give two words, one more slot keeps full rate.
  localparam int QueueDepth = 3;
  localparam int PtrWidth   = $clog2(QueueDepth);
  localparam int QCntWidth  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [WordWidth-1:0]  word;
    logic [CountWidth-1:0] bits;
    logic                  last;
    logic [TotalWidth-1:0] total;
  } result_t;

endpackage

// ===== src/bsc_in_if.sv =====
// ----------------------------------------------------------------------------
// bsc_in_if: segment word channel
// Valid/ready channel carrying one bit segment word.
// ----------------------------------------------------------------------------
interface bsc_in_if;
  logic                                valid;
  logic                                ready;
  logic [bsc_pkg::WordWidth-1:0]       data_word;
  logic [bsc_pkg::CountWidth-1:0]      valid_bits;
  logic                                end_of_stream;

  modport source (output valid, output data_word, output valid_bits,
                  output end_of_stream, input ready);
  modport sink   (input valid, input data_word, input valid_bits,
                  input end_of_stream, output ready);
endinterface

// ===== src/bsc_out_if.sv =====
// ----------------------------------------------------------------------------
// bsc_out_if: merged stream word channel
// Valid/ready channel carrying one packed stream word and its totals.
// ----------------------------------------------------------------------------
interface bsc_out_if;
  logic                                valid;
  logic                                ready;
  logic [bsc_pkg::WordWidth-1:0]       out_word;
  logic [bsc_pkg::CountWidth-1:0]      out_bits;
  logic                                out_last;
  logic [bsc_pkg::TotalWidth-1:0]      total_bits;

  modport source (output valid, output out_word, output out_bits,
                  output out_last, output total_bits, input ready);
  modport sink   (input valid, input out_word, input out_bits,
                  input out_last, input total_bits, output ready);
endinterface

// ===== src/bit_stream_concatenator_top.sv =====
// ----------------------------------------------------------------------------
// bit_stream_concatenator_top: MSB-first bit stream packer
// Appends variable-length segments to a residual word and emits full words.
// ----------------------------------------------------------------------------
// Each accepted word brings 0..64 valid bits from its top end (counts above
// 64 clip to 64, bits below the valid ones are ignored). Bits are appended to
// a residual word; a full 64-bit word goes out as soon as it completes. When
// end_of_stream is set the leftover bits are flushed as a final word with
// zero low bits and out_last high; if the stream ends exactly on a word
// boundary the full word itself carries out_last, and if nothing at all is
// left a zero word with out_bits 0 marks the end. total_bits carries the
// saturating running bit count, including the current word. After the final
// word the block is back at its reset state for the next stream.
// Rate: one input word per clock while the result queue has room. The
// packing is a single pass of shift, mask and add between the residual
// registers and a three-entry result queue, so the input side is never held
// by the datapath. An input that both completes a word and ends the stream
// yields two output words, which leave the output port one after the other;
// the result queue depth bounds how far the input can run ahead of a stalled or slower consumer.
// ----------------------------------------------------------------------------
module bit_stream_concatenator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsc_in_if.sink     in_i,
  bsc_out_if.source  out_o
);

  localparam logic [bsc_pkg::CountWidth-1:0] FullCount =
    bsc_pkg::CountWidth'(bsc_pkg::WordWidth);

  // Packing state
  logic [bsc_pkg::WordWidth-1:0]  res_word_q, res_word_d;
  logic [bsc_pkg::ResWidth-1:0]   res_cnt_q, res_cnt_d;
  logic [bsc_pkg::TotalWidth-1:0] total_q, total_d;

  // Result queue
  bsc_pkg::result_t               slot_q [bsc_pkg::QueueDepth];
  logic [bsc_pkg::PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [bsc_pkg::PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [bsc_pkg::QCntWidth-1:0]  qcnt_q, qcnt_d;

  logic                           in_accept, out_pop;
  logic [bsc_pkg::CountWidth-1:0] len;
  logic [bsc_pkg::WordWidth-1:0]  keep_mask, seg, head, tail;
  logic [bsc_pkg::CountWidth-1:0] sum, shl_amt;
  logic [bsc_pkg::ResWidth-1:0]   rest;
  logic                           full, flush, flush_nonempty;
  logic [bsc_pkg::TotalWidth:0]   total_sum;
  logic [bsc_pkg::TotalWidth-1:0] total_new;
  logic [bsc_pkg::WordWidth-1:0]  after_word;
  logic [bsc_pkg::ResWidth-1:0]   after_cnt;
  bsc_pkg::result_t               res_full, res_flush, res_first;
  logic [1:0]                     n_push;

  function automatic logic [bsc_pkg::PtrWidth-1:0] ptr_inc(
    input logic [bsc_pkg::PtrWidth-1:0] p
  );
    logic [bsc_pkg::PtrWidth-1:0] nxt;
    if (p == bsc_pkg::PtrWidth'(bsc_pkg::QueueDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = p + 1'b1;
    end
    return nxt;
  endfunction

  // Room for two more words, whatever happens at the output this cycle.
  assign in_i.ready = (qcnt_q <= bsc_pkg::QCntWidth'(1));
  assign in_accept  = in_i.valid && in_i.ready;

  assign out_o.valid      = (qcnt_q != '0);
  assign out_o.out_word   = slot_q[rd_ptr_q].word;
  assign out_o.out_bits   = slot_q[rd_ptr_q].bits;
  assign out_o.out_last   = slot_q[rd_ptr_q].last;
  assign out_o.total_bits = slot_q[rd_ptr_q].total;
  assign out_pop          = out_o.valid && out_o.ready;

  // Packing datapath
  always_comb begin
    len = (in_i.valid_bits > FullCount) ? FullCount : in_i.valid_bits;
    // Keep the top len bits; len of zero keeps nothing.
    keep_mask = ~({bsc_pkg::WordWidth{1'b1}} >> len);
    seg       = in_i.data_word & keep_mask;

    head    = res_word_q | (seg >> res_cnt_q);
    sum     = bsc_pkg::CountWidth'(res_cnt_q) + len;
    full    = (len != '0) && (sum >= FullCount);
    rest    = bsc_pkg::ResWidth'(sum - FullCount);
    // Bits that spill past the emitted word; none when residual was empty.
    shl_amt = FullCount - bsc_pkg::CountWidth'(res_cnt_q);
    tail    = seg << shl_amt;

    total_sum = {1'b0, total_q} + (bsc_pkg::TotalWidth + 1)'(len);
    total_new = total_sum[bsc_pkg::TotalWidth] ? {bsc_pkg::TotalWidth{1'b1}}
                                               : total_sum[bsc_pkg::TotalWidth-1:0];

    if (full) begin
      after_word = tail;
      after_cnt  = rest;
    end else if (len != '0) begin
      after_word = head;
      after_cnt  = bsc_pkg::ResWidth'(sum);
    end else begin
      after_word = res_word_q;
      after_cnt  = res_cnt_q;
    end

    flush_nonempty = (after_cnt != '0);
    // Flush word unless a full word already closed the stream exactly.
    flush = in_i.end_of_stream && (flush_nonempty || !full);

    res_full.word  = head;
    res_full.bits  = FullCount;
    res_full.last  = in_i.end_of_stream && (rest == '0);
    res_full.total = total_new;

    res_flush.word  = flush_nonempty ? after_word : '0;
    res_flush.bits  = bsc_pkg::CountWidth'(after_cnt);
    res_flush.last  = 1'b1;
    res_flush.total = total_new;

    res_first = full ? res_full : res_flush;
    n_push    = in_accept ? (2'(full) + 2'(flush)) : 2'd0;

    if (in_accept && in_i.end_of_stream) begin
      res_word_d = '0;
      res_cnt_d  = '0;
      total_d    = '0;
    end else if (in_accept) begin
      res_word_d = after_word;
      res_cnt_d  = after_cnt;
      total_d    = total_new;
    end else begin
      res_word_d = res_word_q;
      res_cnt_d  = res_cnt_q;
      total_d    = total_q;
    end
  end

  // Queue pointers
  always_comb begin
    rd_ptr_d = out_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case (n_push)
      2'd1:    wr_ptr_d = ptr_inc(wr_ptr_q);
      2'd2:    wr_ptr_d = ptr_inc(ptr_inc(wr_ptr_q));
      default: wr_ptr_d = wr_ptr_q;
    endcase
    qcnt_d = qcnt_q + bsc_pkg::QCntWidth'(n_push) - bsc_pkg::QCntWidth'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_word_q <= '0;
      res_cnt_q  <= '0;
      total_q    <= '0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      qcnt_q     <= '0;
    end else begin
      res_word_q <= res_word_d;
      res_cnt_q  <= res_cnt_d;
      total_q    <= total_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      qcnt_q     <= qcnt_d;
    end
  end

  // Result slots: payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      slot_q[wr_ptr_q] <= res_first;
    end
    if (n_push == 2'd2) begin
      slot_q[ptr_inc(wr_ptr_q)] <= res_flush;
    end
  end

endmodule

// ===== src/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// bsc_checker: port-level checks for the bit stream concatenator
// Handshake and stream ordering properties, bound onto the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                in_eos_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [bsc_pkg::WordWidth-1:0]       out_word_i,
  input logic                                out_last_i,
  input logic [bsc_pkg::TotalWidth-1:0]      total_bits_i
);

  logic out_accept;
  assign out_accept = out_valid_i && out_ready_i;

  // A stalled output word stays up.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // ... and keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i) && $stable(total_bits_i))
    else $error("output payload changed while stalled");

  // End of stream always produces at least one word.
  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_eos_i |=> out_valid_i)
    else $error("end of stream gave no output word");

  // With nothing pending the input side must be open.
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result queue");

  // Running total never drops within a stream.
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && $past(out_accept) && !$past(out_last_i)
      |-> total_bits_i >= $past(total_bits_i))
    else $error("running bit total decreased within a stream");

endmodule

bind bit_stream_concatenator_top bsc_checker u_bsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_eos_i     (in_i.end_of_stream),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_word_i   (out_o.out_word),
  .out_last_i   (out_o.out_last),
  .total_bits_i (out_o.total_bits)
);

// ===== dv/bsc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_tb_pkg: expected word tracking for the bit stream concatenator bench
// Packs accepted segments the way the block should and checks each output
// word against the oldest expected one.
// ----------------------------------------------------------------------------
package bsc_tb_pkg;

  import bsc_pkg::*;

  localparam int ReportLimit = 10;

  class merged_word_checker;

    result_t               expected_words[$];
    logic [WordWidth-1:0]  resid_word;
    int unsigned           resid_count;
    logic [TotalWidth-1:0] running_total;
    int unsigned           error_count;

    function new();
      error_count = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      resid_word    = '0;
      resid_count   = 0;
      running_total = '0;
    endfunction

    function void push_word(logic [WordWidth-1:0] w, int unsigned n, bit last);
      result_t e;
      e.word  = w;
      e.bits  = CountWidth'(n);
      e.last  = last;
      e.total = running_total;
      expected_words.insert(expected_words.size(), e);
    endfunction

    // Called once per accepted segment word.
    function void add_segment(logic [WordWidth-1:0] data, logic [CountWidth-1:0] len,
                              logic eos);
      int unsigned          nbits;
      int unsigned          fill;
      logic [WordWidth-1:0] kept;
      logic [TotalWidth:0]  sum;
      bit                   wrote_full;
      nbits = (len > WordWidth) ? WordWidth : len;
      kept  = (nbits == 0) ? '0 : data & ({WordWidth{1'b1}} << (WordWidth - nbits));
      // increment is at most one word, so a carry out means saturate
      sum = {1'b0, running_total} + nbits;
      running_total = sum[TotalWidth] ? '1 : sum[TotalWidth-1:0];
      wrote_full = 1'b0;
      if (nbits != 0) begin
        fill = resid_count + nbits;
        if (fill >= WordWidth) begin
          push_word(resid_word | (kept >> resid_count), WordWidth,
                    eos && fill == WordWidth);
          wrote_full  = 1'b1;
          resid_word  = (resid_count == 0) ? '0 : kept << (WordWidth - resid_count);
          resid_count = fill - WordWidth;
        end else begin
          resid_word  = resid_word | (kept >> resid_count);
          resid_count = fill;
        end
      end
      if (eos) begin
        if (resid_count != 0) begin
          push_word(resid_word, resid_count, 1'b1);
        end else if (!wrote_full) begin
          push_word('0, 0, 1'b1);
        end
        clear_stream();
      end
    endfunction

    function void check_word(result_t got);
      result_t exp;
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit) begin
          $display("unexpected word %h bits %0d last %0b total %0d, none pending",
                   got.word, got.bits, got.last, got.total);
        end
        return;
      end
      exp = expected_words.pop_front();
      if (got.word !== exp.word || got.bits !== exp.bits ||
          got.last !== exp.last || got.total !== exp.total) begin
        error_count++;
        if (error_count <= ReportLimit) begin
          $display("word mismatch: exp %h bits %0d last %0b total %0d", exp.word,
                   exp.bits, exp.last, exp.total);
          $display("               got %h bits %0d last %0b total %0d", got.word,
                   got.bits, got.last, got.total);
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

  endclass

endpackage

// ===== dv/tb_bit_stream_concatenator_top.sv =====
// ----------------------------------------------------------------------------
// tb_bit_stream_concatenator_top: self-checking bench of the stream packer
// Directed edge cases, then random streams under several idle/stall mixes,
// including a long output hold that backs up the input. Every output word is
// checked against a packing model kept in step with accepted input words.
// ----------------------------------------------------------------------------
module tb_bit_stream_concatenator_top;

  import bsc_pkg::*;
  import bsc_tb_pkg::*;

  // Quiet cycles allowed before giving up. Longest legit quiet stretch is the
  // output hold plus a random stall run, well under this.
  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 16;
  localparam int PhaseItems  = 400;

  localparam logic [WordWidth-1:0] AllOnes = {WordWidth{1'b1}};
  localparam logic [WordWidth-1:0] Pattern = 64'hA5A5_5A5A_0123_4567;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bsc_in_if  seg_if ();
  bsc_out_if word_if ();

  bit_stream_concatenator_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (seg_if),
    .out_o  (word_if)
  );

  merged_word_checker word_sb = new();

  int send_idle_pct  = 0;   // chance (percent) the sender skips a cycle
  int recv_stall_pct = 0;   // chance (percent) the receiver drops ready
  bit hold_request   = 1'b0; // ask the receiver for one long hold
  int items_sent     = 0;

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Sender side. valid stays up between back-to-back words; it only drops
  // for an idle gap or at the very end, so there is never a low/high pair of
  // updates in one step.
  // --------------------------------------------------------------------------
  task automatic send_segment(logic [WordWidth-1:0] data, logic [CountWidth-1:0] len,
                              logic eos);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_if.valid         <= 1'b1;
    seg_if.data_word     <= data;
    seg_if.valid_bits    <= len;
    seg_if.end_of_stream <= eos;
    @(posedge clk_i);
    while (!seg_if.ready) @(posedge clk_i);
    // word taken at this edge
    word_sb.add_segment(data, len, eos);
    items_sent++;
  endtask

  // One merged stream: mostly short, now and then long. Lengths mix zero,
  // partial, full and oversized counts; data is random so partial counts come
  // with junk bits below the valid ones.
  task automatic send_random_stream();
    int                    seg_total;
    int                    pick;
    logic [CountWidth-1:0] len;
    seg_total = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
    for (int k = 0; k < seg_total; k++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        len = '0;
      end else if (pick < 12) begin
        len = CountWidth'($urandom_range(127, WordWidth + 1));
      end else if (pick < 35) begin
        len = CountWidth'(WordWidth);
      end else begin
        len = CountWidth'($urandom_range(WordWidth - 1, 1));
      end
      send_segment({$urandom, $urandom}, len, k == seg_total - 1);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_request   = with_hold;
    start          = items_sent;
    while (items_sent - start < PhaseItems) send_random_stream();
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each taken word, then picks next cycle's ready.
  // A hold is counted down here, independent of the sender.
  // --------------------------------------------------------------------------
  initial begin : word_sink
    int      hold_left;
    result_t got;
    hold_left = 0;
    word_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (word_if.valid && word_if.ready) begin
        got.word  = word_if.out_word;
        got.bits  = word_if.out_bits;
        got.last  = word_if.out_last;
        got.total = word_if.total_bits;
        word_sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        word_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles - 1;
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles without any word moving on either side.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((seg_if.valid && seg_if.ready) || (word_if.valid && word_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    seg_if.valid         <= 1'b0;
    seg_if.data_word     <= '0;
    seg_if.valid_bits    <= '0;
    seg_if.end_of_stream <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases, no idling on either side.
    // empty end straight out of reset: zero word, zero bits, last
    send_segment(AllOnes, 0, 1'b1);
    // full word alone, then a full word that ends the stream exactly
    send_segment(AllOnes, 64, 1'b0);
    send_segment(Pattern, 64, 1'b1);
    // oversized counts clip to a full word
    send_segment(Pattern, 127, 1'b0);
    send_segment(~Pattern, 65, 1'b0);
    // junk below the valid bits must not leak in
    send_segment(AllOnes, 4, 1'b0);
    // zero length in mid stream appends nothing
    send_segment(AllOnes, 0, 1'b0);
    // residual 4 + 60 ends exactly on a word boundary: one word, last
    send_segment(~Pattern, 60, 1'b1);
    // 1 + 63 fills a word with no end
    send_segment(AllOnes, 1, 1'b0);
    send_segment('0, 63, 1'b0);
    // 10 + 60 with end: full word then a 6-bit flush
    send_segment(Pattern, 10, 1'b0);
    send_segment(AllOnes, 60, 1'b1);
    // zero-length word carries the end with bits still held
    send_segment(Pattern, 33, 1'b0);
    send_segment(AllOnes, 0, 1'b1);
    // end right after a full word went out: nothing left, empty end marker
    send_segment(~Pattern, 64, 1'b0);
    send_segment(AllOnes, 0, 1'b1);
    // one-bit stream of a zero bit
    send_segment('0, 1, 1'b1);
    // 1 + 62 + 2 crosses the boundary by one bit at the end
    send_segment(AllOnes, 1, 1'b0);
    send_segment(AllOnes, 62, 1'b0);
    send_segment(Pattern, 2, 1'b1);
    // oversized count on the ending word
    send_segment(~Pattern, 127, 1'b1);
    // the 40-bit total cannot saturate in a run of this size

    // Random streams under different handshake mixes. The first long hold is
    // asked with the sender running flat out so the block backs up.
    run_phase(0, 0, 1'b1);
    run_phase(67, 0, 1'b0);
    run_phase(0, 67, 1'b0);
    run_phase(35, 35, 1'b1);
    run_phase(0, 0, 1'b0);
    seg_if.valid <= 1'b0;

    recv_stall_pct = 0;
    while (word_sb.pending() != 0) @(posedge clk_i);
    // let any stray extra word show up
    repeat (DrainCycles) @(posedge clk_i);

    if (word_sb.error_count == 0 && word_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
